// ----- src/rhlru_pkg.sv -----
// Package for the Robin Hood slot cache: sizes, mode codes and the hash function.
// No dependencies.
`default_nettype none
package rhlru_pkg;
  localparam int MaxEntries = 256;
  localparam int Buckets = 512;
  localparam int BW = $clog2(Buckets);
  localparam int SW = $clog2(MaxEntries);
  localparam int CW = $clog2(MaxEntries + 1);
  localparam int Target = MaxEntries / 3 * 2;
  localparam int BrowW = 24 + 8 + SW;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Low 32 bits of the product, folded and reduced to a bucket index.
  function automatic logic [BW-1:0] home_of(input logic [23:0] k);
    logic [55:0] p;
    logic [31:0] h;
    p = {32'd0, k} * 56'd2654435761;
    h = p[31:0];
    h = h ^ (h >> 16);
    return h[BW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- src/robin_hood_lru_slot_cache.sv -----
// Robin Hood slot cache with pseudo-LRU eviction: sequencer, bucket and free stack RAMs.
// Depends on rhlru_pkg and rhlru_ram.
//
// This cache maps 24-bit keys to storage slots through a 512-bucket Robin Hood
// hash table. Each word on s_axis carries a mode (lookup, insert, tick, clear)
// and a key; each accepted word produces exactly one word on m_axis with the hit
// flag, the slot's byte offset (slot times slot_bytes) and the live entry count.
// The block takes one word at a time. A bucket RAM with one registered port is
// walked bucket by bucket by a single sequencer, with a read state and then a
// check state for each bucket; a lookup walks the probe sequence, an insert walks
// up to an empty bucket, and a tick or an eviction runs a sweep of up to 512
// buckets, freeing each entry it removes. Clear sweeps all 512 buckets and the
// free stack. After reset the same clearing pass runs once before the first
// word is accepted; slot_bytes writes are taken any time.
// The result is held in an output register until m_axis takes it.
`default_nettype none
module robin_hood_lru_slot_cache (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // mode[1:0], key[25:2], zero fill
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // hit[0], slot_offset[20:1], entry_count[29:21]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data        // slot_bytes
);
  import rhlru_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_PRD, S_PCHK, S_IFULL, S_POP, S_IRD, S_ICHK,
    S_SWRD, S_SWCHK, S_SWFREE, S_MUL, S_DONE
  } state_t;

  state_t state;
  logic [12:0] slot_bytes;
  logic [1:0] mode;
  logic [23:0] key;
  logic [BW-1:0] b;
  logic [BW:0] d, n;
  logic [CW-1:0] live_count;
  logic [31:0] tick_now;
  logic [3:0] cutoff_gap;
  logic [15:0] lfsr;
  logic [BW-1:0] init_i;
  logic [8:0] thr;          // signed threshold, -1 removes anything
  logic sweep_ins;          // sweep was started by an insert
  logic [23:0] ck;
  logic [SW-1:0] cs, result;
  logic [7:0] cst;
  logic hit;
  logic [19:0] off;
  logic [BW-1:0] homereg;

  // Bucket RAM: live, key, stamp, slot.
  logic bwe;
  logic [BW-1:0] baddr;
  logic [BrowW:0] bwdata, brd;
  rhlru_ram #(.Width(BrowW + 1), .Depth(Buckets)) u_bkt (
    .clk(clk), .we(bwe), .addr(baddr), .wdata(bwdata), .rdata(brd));
  logic r_live;
  logic [23:0] r_key;
  logic [7:0] r_stamp;
  logic [SW-1:0] r_slot;
  assign {r_live, r_key, r_stamp, r_slot} = brd;

  // Free stack RAM.
  logic fwe;
  logic [SW-1:0] faddr, fwdata, frd;
  rhlru_ram #(.Width(SW), .Depth(MaxEntries)) u_free (
    .clk(clk), .we(fwe), .addr(faddr), .wdata(fwdata), .rdata(frd));

  logic [BW-1:0] r_dist;
  assign r_dist = b - home_of(r_key);
  logic [7:0] age;
  assign age = tick_now[7:0] - r_stamp;
  logic [15:0] lfsr_nx;
  assign lfsr_nx = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
  logic [SW:0] top_idx;   // MaxEntries - live_count
  assign top_idx = (SW+1)'(MaxEntries) - (SW+1)'(live_count);

  always_comb begin
    bwe = 1'b0; baddr = b; bwdata = '0;
    fwe = 1'b0; faddr = '0; fwdata = '0;
    unique case (state)
      S_INIT: begin
        bwe = 1'b1; baddr = init_i;
        fwe = ({1'b0, init_i} < (BW+1)'(MaxEntries));
        faddr = init_i[SW-1:0]; fwdata = init_i[SW-1:0];
      end
      S_PCHK: if (r_live && r_key == key) begin
        bwe = 1'b1; bwdata = {1'b1, r_key, tick_now[7:0], r_slot};
      end
      S_POP: faddr = SW'(top_idx - 1'b1);
      S_ICHK: if (!r_live || r_dist < d[BW-1:0]) begin
        bwe = 1'b1; bwdata = {1'b1, ck, cst, cs};
      end
      S_SWCHK: if (r_live && $signed({1'b0, age}) > $signed(thr)) begin
        bwe = 1'b1; bwdata = {1'b0, r_key, r_stamp, r_slot};
      end
      S_SWFREE: begin
        fwe = 1'b1; faddr = top_idx[SW-1:0]; fwdata = cs;
      end
      default: ;
    endcase
  end

  // init_i walks every bucket; the free stack is refilled on the first
  // MaxEntries of them, since Buckets >= MaxEntries here.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; init_i <= '0; slot_bytes <= 13'd128; live_count <= '0;
      tick_now <= '0; cutoff_gap <= '0; lfsr <= 16'hACE1; m_axis_tvalid <= 1'b0;
      mode <= '0;
    end else begin
      if (cfg_valid) slot_bytes <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_INIT: begin
          init_i <= init_i + 1'b1;
          if (init_i == BW'(Buckets - 1)) begin
            live_count <= '0;
            if (mode == MODE_CLEAR) begin
              hit <= 1'b0; off <= '0; state <= S_DONE;
            end else state <= S_IDLE;
          end
        end
        S_IDLE: if (s_axis_tvalid) begin
          mode <= s_axis_tdata[1:0]; key <= s_axis_tdata[25:2];
          hit <= 1'b0; off <= '0; sweep_ins <= 1'b0;
          unique case (mode_t'(s_axis_tdata[1:0]))
            MODE_LOOKUP, MODE_INSERT: state <= S_HASH;
            MODE_TICK: begin
              tick_now <= tick_now + 1'b1; cutoff_gap <= 4'd4; thr <= 9'd4;
              lfsr <= lfsr_nx; b <= lfsr_nx[BW-1:0]; n <= '0; state <= S_SWRD;
            end
            default: begin init_i <= '0; state <= S_INIT; end
          endcase
        end
        S_HASH: begin
          homereg <= home_of(key); b <= home_of(key); d <= '0;
          state <= (mode == MODE_LOOKUP) ? S_PRD : S_IFULL;
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (r_live && r_key == key) begin
            hit <= 1'b1; cs <= r_slot; state <= S_MUL;
          end else if ({1'b0, r_dist} < d || d == (BW+1)'(Buckets - 1)) begin
            state <= S_DONE;
          end else begin
            d <= d + 1'b1; b <= b + 1'b1; state <= S_PRD;
          end
        end
        S_IFULL: begin
          if (live_count >= CW'(MaxEntries)) begin
            sweep_ins <= 1'b1;
            if (cutoff_gap != 0) begin
              cutoff_gap <= cutoff_gap - 1'b1; thr <= {5'd0, cutoff_gap - 1'b1};
            end else thr <= 9'h1FF;
            lfsr <= lfsr_nx; b <= lfsr_nx[BW-1:0]; n <= '0; state <= S_SWRD;
          end else begin
            // A sweep may have moved b; the probe restarts at home with n
            // counting its steps.
            b <= homereg; d <= '0; n <= '0; state <= S_POP;
          end
        end
        S_POP: state <= S_IRD;  // free stack read issued
        S_IRD: begin
          if (d == '0 && b == homereg) begin
            result <= frd; cs <= frd; ck <= key; cst <= tick_now[7:0];
            live_count <= live_count + 1'b1;
          end
          state <= S_ICHK;
        end
        S_ICHK: begin
          if (!r_live) begin
            hit <= 1'b1; cs <= result; state <= S_MUL;
          end else begin
            if (r_dist < d[BW-1:0]) begin
              ck <= r_key; cs <= r_slot; cst <= r_stamp; d <= {1'b0, r_dist} + 1'b1;
            end else d <= d + 1'b1;
            b <= b + 1'b1;
            if (n == (BW+1)'(Buckets - 1)) begin
              // No empty bucket: drop the carried entry.
              sweep_ins <= 1'b0; state <= S_SWFREE;
            end else begin
              n <= n + 1'b1; state <= S_IRD;
            end
          end
        end
        S_SWRD: begin
          if (live_count <= CW'(Target) || n == (BW+1)'(Buckets)) begin
            if (sweep_ins) state <= S_IFULL; else state <= S_DONE;
          end else state <= S_SWCHK;
        end
        S_SWCHK: begin
          n <= n + 1'b1;
          if (r_live && $signed({1'b0, age}) > $signed(thr)) begin
            cs <= r_slot; lfsr <= lfsr_nx; b <= lfsr_nx[BW-1:0] + 1'b1;
            state <= S_SWFREE;
          end else begin
            b <= b + 1'b1; state <= S_SWRD;
          end
        end
        S_SWFREE: begin
          if (live_count != 0) live_count <= live_count - 1'b1;
          if (mode == MODE_INSERT && !sweep_ins && hit == 1'b0) begin
            hit <= 1'b1; cs <= result; state <= S_MUL;
          end else state <= S_SWRD;
        end
        S_MUL: begin
          off <= {12'd0, cs} * {7'd0, slot_bytes}; state <= S_DONE;
        end
        S_DONE: if (!m_axis_tvalid) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {2'b0, 9'(live_count), off, hit};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
endmodule
`default_nettype wire

// ----- src/rhlru_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rhlru_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
